FILE: rtl/core/kr_pkg.sv
// ----------------------------------------------------------------------------
// kr_pkg
// Shared types and constant tables for the keyword recogniser: the reserved
// word spellings, their lengths and the class each one reports.
// ----------------------------------------------------------------------------
package kr_pkg;

   localparam int WORD_COUNT = 17;
   localparam int MAX_LEN    = 10;
   localparam int POS_W      = 4;
   localparam int CHAR_W     = 8;

   localparam logic [POS_W-1:0] POS_MAX = '1;

   typedef enum logic [1:0] {
      CLASS_PLAIN    = 2'd0,
      CLASS_KEYWORD  = 2'd1,
      CLASS_OPERATOR = 2'd2
   } token_class_type;

   typedef logic [CHAR_W-1:0]     char_type;
   typedef logic [POS_W-1:0]      pos_type;
   typedef logic [WORD_COUNT-1:0] live_type;

   // Result of one comparison pass over all words
   typedef struct packed {
      live_type        live;
      token_class_type token_class;
   } match_result_type;

   // Spellings, padded with zero bytes past the word length
   localparam char_type WORD_TEXT [WORD_COUNT][MAX_LEN] = '{
      '{"f", "u", "n", "c", "t", "i", "o", "n", 8'h00, 8'h00},
      '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"f", "o", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"d", "o", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"s", "w", "i", "t", "c", "h", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"c", "a", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"b", "r", "e", "a", "k", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"i", "n", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"n", "e", "w", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"t", "y", "p", "e", "o", "f", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"v", "o", "i", "d", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"d", "e", "l", "e", "t", "e", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"i", "n", "s", "t", "a", "n", "c", "e", "o", "f"},
      '{"y", "i", "e", "l", "d", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
   };

   localparam pos_type WORD_LEN [WORD_COUNT] = '{
      4'd8, 4'd6, 4'd2, 4'd4, 4'd3, 4'd5, 4'd2, 4'd6, 4'd4, 4'd5,
      4'd2, 4'd3, 4'd6, 4'd4, 4'd6, 4'd10, 4'd5
   };

   localparam token_class_type WORD_CLASS [WORD_COUNT] = '{
      CLASS_KEYWORD, CLASS_KEYWORD, CLASS_KEYWORD, CLASS_KEYWORD, CLASS_KEYWORD,
      CLASS_KEYWORD, CLASS_KEYWORD, CLASS_KEYWORD, CLASS_KEYWORD, CLASS_KEYWORD,
      CLASS_OPERATOR, CLASS_OPERATOR, CLASS_OPERATOR, CLASS_OPERATOR,
      CLASS_OPERATOR, CLASS_OPERATOR, CLASS_OPERATOR
   };

endpackage

FILE: rtl/core/kr_match.sv
// ----------------------------------------------------------------------------
// kr_match
// Compares one character against every word at the current position, giving
// the surviving live bits and the class of the first exact full-length match.
// ----------------------------------------------------------------------------
module kr_match (
   input  kr_pkg::char_type         symbol_char,
   input  kr_pkg::pos_type          char_pos,
   input  kr_pkg::live_type         live,
   output kr_pkg::match_result_type result
);
   import kr_pkg::*;

   live_type            next_live;
   token_class_type     cls;
   logic [POS_W:0]      taken;

   assign taken = {1'b0, char_pos} + {{POS_W{1'b0}}, 1'b1};

   // Per-word compare, all words in parallel
   always_comb begin
      for (int i = 0; i < WORD_COUNT; i++) begin
         next_live[i] = live[i] && (char_pos < WORD_LEN[i]) &&
                        (WORD_TEXT[i][char_pos] == symbol_char);
      end
   end

   // Lowest-numbered exact match wins; scan downwards so it overwrites
   always_comb begin
      cls = CLASS_PLAIN;
      for (int i = WORD_COUNT - 1; i >= 0; i--) begin
         if (next_live[i] && ({1'b0, WORD_LEN[i]} == taken)) begin
            cls = WORD_CLASS[i];
         end
      end
   end

   assign result.live        = next_live;
   assign result.token_class = cls;

endmodule

FILE: rtl/core/keyword_recognizer.sv
// ----------------------------------------------------------------------------
// keyword_recognizer
// Classifies an identifier streamed one character per word as plain name,
// reserved keyword or word operator.
// ----------------------------------------------------------------------------
// Path: input register, then result register, which drives rsp_.
// Throughput: 1 character per cycle; the input register and the result
//   register decouple the two sides, so a waiting result does not stall input
//   unless another last character needs the result register.
// Reset: synchronous, clears the valids, all words live, position zero.
// ----------------------------------------------------------------------------
module keyword_recognizer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] symbol_char
   input  logic       req_tlast,   // is_last
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [1:0] token_class, [7:2] zero
);
   import kr_pkg::*;

   logic             in_valid_ff, in_valid_in;
   char_type         char_ff;
   logic             last_ff;
   live_type         live_ff, live_in;
   pos_type          pos_ff, pos_in;
   logic             rsp_valid_ff, rsp_valid_in;
   token_class_type  class_ff;
   match_result_type match;
   logic             out_free;
   logic             advance;

   // Stage handshake
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && (!last_ff || out_free);
   assign req_tready = !in_valid_ff || advance;

   kr_match u_match (
      .symbol_char (char_ff),
      .char_pos    (pos_ff),
      .live        (live_ff),
      .result      (match)
   );

   // Next-state logic
   always_comb begin
      in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
      live_in      = live_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (advance) begin
         if (last_ff) begin
            live_in      = '1;
            pos_in       = '0;
            rsp_valid_in = 1'b1;
         end else begin
            live_in = match.live;
            pos_in  = (pos_ff == POS_MAX) ? POS_MAX : pos_ff + 1'b1;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         live_ff      <= '1;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         live_ff      <= live_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         char_ff <= req_tdata;
         last_ff <= req_tlast;
      end
      if (advance && last_ff) begin
         class_ff <= match.token_class;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, class_ff};

`ifndef SYNTHESIS
   // Class code 3 is never produced
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (class_ff != 2'd3))
      else $error("invalid token class");

   // A finished identifier restarts matching from scratch
   assert property (@(posedge clock) disable iff (reset)
      (advance && last_ff) |=> (live_ff == '1) && (pos_ff == '0))
      else $error("match state not restarted after last character");

   // A new result only appears after a last character left the input stage
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance && last_ff))
      else $error("result without a last character");

   // Position only moves when a character advances
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(pos_ff) && $stable(live_ff))
      else $error("match state changed without a character");
`endif

endmodule
